### hw/rtl/dtk_pkg.sv
// Shared types and constants for the detection top-k selection block.
package dtk_pkg;

    // Register indexes on the configuration channel.
    localparam logic [1:0] CFG_CLASS_COUNT = 2'd0;
    localparam logic [1:0] CFG_MAX_DET     = 2'd1;
    localparam logic [1:0] CFG_OUT_ROWS    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] CLASS_COUNT_RST = 8'd80;
    localparam logic [6:0] MAX_DET_RST     = 7'd64;
    localparam logic [6:0] OUT_ROWS_RST    = 7'd64;

    // Largest number of result rows per prediction set.
    localparam logic [6:0] ROWS_MAX = 7'd64;

    // Item kinds.
    localparam logic KIND_BOX = 1'b0;

    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
    } box_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] box_x1;
        logic signed [31:0] box_y1;
        logic signed [31:0] box_x2;
        logic signed [31:0] box_y2;
        logic        [15:0] score;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x1;
        logic signed [31:0] out_y1;
        logic signed [31:0] out_x2;
        logic signed [31:0] out_y2;
        logic        [15:0] out_score;
        logic        [6:0]  out_class;
        logic               row_last;
    } out_item_t;

    // Write strobes from the control logic to the storage.
    typedef struct packed {
        logic sc_we;
        logic box_we;
    } store_ctl_t;

endpackage

### hw/rtl/dtk_store.sv
// Score and box memories, addressed by physical anchor slot (scores also by class).
module dtk_store #(
    parameter int SLOT_W = 7,
    parameter int CLS_W  = 7
) (
    input  logic                     clk,
    input  dtk_pkg::store_ctl_t      ctl,
    input  logic [SLOT_W+CLS_W-1:0]  sc_waddr,
    input  logic [15:0]              sc_wdata,
    input  logic [SLOT_W+CLS_W-1:0]  sc_raddr,
    output logic [15:0]              sc_rdata,
    input  logic [SLOT_W-1:0]        box_waddr,
    input  dtk_pkg::box_t            box_wdata,
    input  logic [SLOT_W-1:0]        box_raddr,
    output dtk_pkg::box_t            box_rdata
);
    import dtk_pkg::*;

    localparam int SC_DEPTH  = 1 << (SLOT_W + CLS_W);
    localparam int BOX_DEPTH = 1 << SLOT_W;

    logic [15:0] sc_mem [SC_DEPTH];
    box_t        box_mem [BOX_DEPTH];
    logic [15:0] sc_rdata_reg;
    box_t        box_rdata_reg;

    // Score memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.sc_we)
        begin
            sc_mem[sc_waddr] <= sc_wdata;
        end
        sc_rdata_reg <= sc_mem[sc_raddr];
    end

    // Box memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.box_we)
        begin
            box_mem[box_waddr] <= box_wdata;
        end
        box_rdata_reg <= box_mem[box_raddr];
    end

    assign sc_rdata  = sc_rdata_reg;
    assign box_rdata = box_rdata_reg;

endmodule

### hw/rtl/detection_topk_select.sv
// Top level of the detection top-k selection block.
//
// Items enter on start/item when busy is low: a box item opens an anchor and
// the following score items, one per configured class, complete it. A normal
// item is taken in ST_IDLE; the score item that completes an anchor also
// passes ST_CMP, where the ranked list is compared against the anchor
// maximum, and ST_INS, where it is shifted. The item flagged last then
// starts the output pass, and busy stays high until every row has gone out.
// Each output row is found by a full sweep of the kept scores through the
// score memory, one read a cycle, followed by ST_DRAIN, ST_BOXRD and ST_OUT;
// a zero row goes from ST_PREP straight to ST_OUT. Rows appear on result for
// one cycle each, marked by result_valid; the receiver cannot stall them.
// Configuration writes are taken in every cycle (cfg_ready is always high).
// Reset restores the register defaults and empties the kept list; the
// memories need no clearing pass.
module detection_topk_select #(
    parameter int NC_MAX = 128,
    parameter int K_MAX  = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dtk_pkg::in_item_t  item,
    output logic               result_valid,
    output dtk_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import dtk_pkg::*;

    localparam int SLOT_W = $clog2(K_MAX + 1);
    localparam int RANK_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CLS_W  = (NC_MAX > 1) ? $clog2(NC_MAX) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMP   = 3'd1;
    localparam logic [2:0] ST_INS   = 3'd2;
    localparam logic [2:0] ST_PREP  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_BOXRD = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [7:0]        nc_cfg_reg;
    logic [6:0]        md_cfg_reg, rows_cfg_reg;

    logic              open_reg, open_next;
    logic [8:0]        cp_reg, cp_next;
    logic [15:0]       pmax_reg, pmax_next;
    logic [6:0]        count_reg, count_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic              last_pend_reg, last_pend_next;

    logic [SLOT_W-1:0] perm_reg [K_MAX];
    logic [SLOT_W-1:0] perm_next [K_MAX];
    logic [15:0]       rmax_reg [K_MAX];
    logic [15:0]       rmax_next [K_MAX];
    logic [K_MAX-1:0]  ge_reg, ge_next;

    logic [6:0]        t_reg, t_next;
    logic [RANK_W-1:0] a_reg, a_next;
    logic [CLS_W-1:0]  c_reg, c_next;
    logic              rd_v_reg, rd_v_next;
    logic [RANK_W-1:0] rd_a_reg, rd_a_next;
    logic [CLS_W-1:0]  rd_c_reg, rd_c_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;

    logic              prev_v_reg, prev_v_next;
    logic [15:0]       prev_s_reg, prev_s_next;
    logic [RANK_W-1:0] prev_a_reg, prev_a_next;
    logic [CLS_W-1:0]  prev_c_reg, prev_c_next;
    logic              found_reg, found_next;
    logic [15:0]       best_s_reg, best_s_next;
    logic [RANK_W-1:0] best_a_reg, best_a_next;
    logic [CLS_W-1:0]  best_c_reg, best_c_next;
    logic [SLOT_W-1:0] best_slot_reg, best_slot_next;

    logic              done_reg, done_next;
    out_item_t         res_reg, res_next;

    logic [8:0]        nc_eff;
    logic [6:0]        rows_eff, md_eff, cap, n_kept;
    logic [6:0]        ins_pos, shift_end;
    logic              cand;

    store_ctl_t              ctl;
    logic [SLOT_W+CLS_W-1:0] sc_waddr, sc_raddr;
    logic [SLOT_W-1:0]       box_raddr;
    logic [15:0]             sc_rdata;
    box_t                    box_wdata, box_rdata;

    // Effective register values, clamped into range.
    always_comb
    begin
        if (nc_cfg_reg == 8'd0)
            nc_eff = 9'd1;
        else if ({1'b0, nc_cfg_reg} > 9'(NC_MAX))
            nc_eff = 9'(NC_MAX);
        else
            nc_eff = {1'b0, nc_cfg_reg};

        if (rows_cfg_reg == 7'd0)
            rows_eff = 7'd1;
        else if (rows_cfg_reg > ROWS_MAX)
            rows_eff = ROWS_MAX;
        else
            rows_eff = rows_cfg_reg;

        md_eff = (md_cfg_reg == 7'd0) ? 7'd1 : md_cfg_reg;
        cap    = (md_eff < rows_eff) ? md_eff : rows_eff;
        if (cap > 7'(K_MAX))
            cap = 7'(K_MAX);
        n_kept = (count_reg < cap) ? count_reg : cap;
    end

    // Insertion point: the first rank that is empty or whose maximum is below the new anchor's.
    always_comb
    begin
        ins_pos = 7'(K_MAX);
        for (int i = K_MAX - 1; i >= 0; i--)
        begin
            if (!ge_reg[i])
                ins_pos = 7'(i);
        end
        shift_end = (n_kept < cap) ? n_kept : cap - 7'd1;
    end

    // A returned score is a candidate if it ranks strictly after the previous row.
    always_comb
    begin
        cand = !prev_v_reg || (sc_rdata < prev_s_reg) ||
               ((sc_rdata == prev_s_reg) &&
                ((rd_a_reg > prev_a_reg) ||
                 ((rd_a_reg == prev_a_reg) && (rd_c_reg > prev_c_reg))));
    end

    assign box_wdata = '{x1: item.box_x1, y1: item.box_y1, x2: item.box_x2, y2: item.box_y2};

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        cp_next        = cp_reg;
        pmax_next      = pmax_reg;
        count_next     = count_reg;
        pend_slot_next = pend_slot_reg;
        last_pend_next = last_pend_reg;
        perm_next      = perm_reg;
        rmax_next      = rmax_reg;
        ge_next        = ge_reg;
        t_next         = t_reg;
        a_next         = a_reg;
        c_next         = c_reg;
        rd_v_next      = 1'b0;
        rd_a_next      = a_reg;
        rd_c_next      = c_reg;
        rd_slot_next   = perm_reg[a_reg];
        prev_v_next    = prev_v_reg;
        prev_s_next    = prev_s_reg;
        prev_a_next    = prev_a_reg;
        prev_c_next    = prev_c_reg;
        found_next     = found_reg;
        best_s_next    = best_s_reg;
        best_a_next    = best_a_reg;
        best_c_next    = best_c_reg;
        best_slot_next = best_slot_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        ctl            = '0;
        sc_waddr       = {pend_slot_reg, cp_reg[CLS_W-1:0]};
        sc_raddr       = {perm_reg[a_reg], c_reg};
        box_raddr      = best_slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.kind == KIND_BOX)
                    begin
                        ctl.box_we = 1'b1;
                        open_next  = 1'b1;
                        cp_next    = 9'd0;
                        pmax_next  = 16'd0;
                    end
                    else if (open_reg)
                    begin
                        if (cp_reg < nc_eff)
                        begin
                            ctl.sc_we = 1'b1;
                            if (item.score > pmax_reg)
                                pmax_next = item.score;
                            cp_next = cp_reg + 9'd1;
                        end
                        if (cp_next >= nc_eff)
                        begin
                            open_next  = 1'b0;
                            state_next = ST_CMP;
                        end
                    end
                    last_pend_next = item.last;
                    if (item.last && (state_next == ST_IDLE))
                    begin
                        t_next      = 7'd0;
                        prev_v_next = 1'b0;
                        state_next  = ST_PREP;
                    end
                end
            end

            ST_CMP:
            begin
                for (int i = 0; i < K_MAX; i++)
                begin
                    ge_next[i] = (7'(i) < n_kept) && (rmax_reg[i] >= pmax_reg);
                end
                state_next = ST_INS;
            end

            ST_INS:
            begin
                if (ins_pos < cap)
                begin
                    for (int i = 0; i < K_MAX; i++)
                    begin
                        if (7'(i) == ins_pos)
                        begin
                            perm_next[i] = pend_slot_reg;
                            rmax_next[i] = pmax_reg;
                        end
                        else if ((7'(i) > ins_pos) && (7'(i) <= shift_end))
                        begin
                            perm_next[i] = perm_reg[i-1];
                            rmax_next[i] = rmax_reg[i-1];
                        end
                    end
                    pend_slot_next = perm_reg[shift_end[RANK_W-1:0]];
                    count_next     = (n_kept < cap) ? n_kept + 7'd1 : cap;
                end
                if (last_pend_reg)
                begin
                    t_next      = 7'd0;
                    prev_v_next = 1'b0;
                    state_next  = ST_PREP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PREP:
            begin
                if (t_reg < n_kept)
                begin
                    a_next     = '0;
                    c_next     = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_SCAN:
            begin
                rd_v_next = 1'b1;
                if (9'(c_reg) == nc_eff - 9'd1)
                begin
                    c_next = '0;
                    if (7'(a_reg) == n_kept - 7'd1)
                        state_next = ST_DRAIN;
                    else
                        a_next = a_reg + 1'b1;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_BOXRD;
            end

            ST_BOXRD:
            begin
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                done_next = 1'b1;
                res_next  = '0;
                if (t_reg < n_kept)
                begin
                    res_next.out_x1    = box_rdata.x1;
                    res_next.out_y1    = box_rdata.y1;
                    res_next.out_x2    = box_rdata.x2;
                    res_next.out_y2    = box_rdata.y2;
                    res_next.out_score = best_s_reg;
                    res_next.out_class = 7'(best_c_reg);
                end
                res_next.row_last = (t_reg + 7'd1 == rows_eff);
                prev_v_next = 1'b1;
                prev_s_next = best_s_reg;
                prev_a_next = best_a_reg;
                prev_c_next = best_c_reg;
                t_next      = t_reg + 7'd1;
                if (t_reg + 7'd1 == rows_eff)
                begin
                    count_next = 7'd0;
                    open_next  = 1'b0;
                    cp_next    = 9'd0;
                    pmax_next  = 16'd0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Track the best candidate among the returned scores.
        if (rd_v_reg && cand && (!found_reg || (sc_rdata > best_s_reg)))
        begin
            found_next     = 1'b1;
            best_s_next    = sc_rdata;
            best_a_next    = rd_a_reg;
            best_c_next    = rd_c_reg;
            best_slot_next = rd_slot_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nc_cfg_reg    <= CLASS_COUNT_RST;
            md_cfg_reg    <= MAX_DET_RST;
            rows_cfg_reg  <= OUT_ROWS_RST;
            open_reg      <= 1'b0;
            cp_reg        <= 9'd0;
            pmax_reg      <= 16'd0;
            count_reg     <= 7'd0;
            pend_slot_reg <= SLOT_W'(K_MAX);
            last_pend_reg <= 1'b0;
            for (int i = 0; i < K_MAX; i++)
            begin
                perm_reg[i] <= SLOT_W'(i);
            end
            t_reg         <= 7'd0;
            rd_v_reg      <= 1'b0;
            prev_v_reg    <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            cp_reg        <= cp_next;
            pmax_reg      <= pmax_next;
            count_reg     <= count_next;
            pend_slot_reg <= pend_slot_next;
            last_pend_reg <= last_pend_next;
            perm_reg      <= perm_next;
            t_reg         <= t_next;
            rd_v_reg      <= rd_v_next;
            prev_v_reg    <= prev_v_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_CLASS_COUNT: nc_cfg_reg   <= cfg_data;
                    CFG_MAX_DET:     md_cfg_reg   <= cfg_data[6:0];
                    CFG_OUT_ROWS:    rows_cfg_reg <= cfg_data[6:0];
                    default:         ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rmax_reg      <= rmax_next;
        ge_reg        <= ge_next;
        a_reg         <= a_next;
        c_reg         <= c_next;
        rd_a_reg      <= rd_a_next;
        rd_c_reg      <= rd_c_next;
        rd_slot_reg   <= rd_slot_next;
        prev_s_reg    <= prev_s_next;
        prev_a_reg    <= prev_a_next;
        prev_c_reg    <= prev_c_next;
        best_s_reg    <= best_s_next;
        best_a_reg    <= best_a_next;
        best_c_reg    <= best_c_next;
        best_slot_reg <= best_slot_next;
        res_reg       <= res_next;
    end

    dtk_store #(
        .SLOT_W(SLOT_W),
        .CLS_W (CLS_W)
    ) u_store (
        .clk      (clk),
        .ctl      (ctl),
        .sc_waddr (sc_waddr),
        .sc_wdata (item.score),
        .sc_raddr (sc_raddr),
        .sc_rdata (sc_rdata),
        .box_waddr(pend_slot_reg),
        .box_wdata(box_wdata),
        .box_raddr(box_raddr),
        .box_rdata(box_rdata)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = done_reg;
    assign result       = res_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the detection top-k selection block.
module tb_top;
    import dtk_pkg::*;

    localparam int NC_LIMIT   = 128;
    localparam int KEEP_LIMIT = 64;
    localparam int ROW_LIMIT  = 64;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   item;
    logic       result_valid;
    out_item_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    detection_topk_select uut (.*);

    // Register copies held by the predictor.
    logic [7:0] class_count_reg;
    logic [6:0] max_det_reg;
    logic [6:0] out_rows_reg;

    // Anchor being collected and the ranked list of kept anchors.
    logic [15:0] open_scores [NC_LIMIT];
    box_t        open_box;
    logic [15:0] open_max;
    int          open_pos;
    bit          anchor_open;
    int          kept_total;
    logic [15:0] kept_max [KEEP_LIMIT];
    box_t        kept_box [KEEP_LIMIT];
    logic [15:0] kept_scores [KEEP_LIMIT][NC_LIMIT];
    int          rank_slot [KEEP_LIMIT];

    out_item_t   expected_rows [$];
    out_item_t   want;
    int          fails;
    int          items_sent;
    int          burst_left;
    bit          start_high;

    // Clock and watchdog timeout.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** detection_topk_select: FAILED **");
        $finish;
    end

    function automatic int classes_in_use();
        if (class_count_reg == 0) return 1;
        return (class_count_reg > NC_LIMIT) ? NC_LIMIT : int'(class_count_reg);
    endfunction

    function automatic int rows_in_use();
        if (out_rows_reg == 0) return 1;
        return (out_rows_reg > ROW_LIMIT) ? ROW_LIMIT : int'(out_rows_reg);
    endfunction

    function automatic int keep_cap();
        int c;
        c = (max_det_reg == 0) ? 1 : int'(max_det_reg);
        if (rows_in_use() < c) c = rows_in_use();
        if (c > KEEP_LIMIT) c = KEEP_LIMIT;
        return c;
    endfunction

    // Insert the completed anchor into the ranked list; equal maxima keep earlier anchors ahead.
    task automatic insert_anchor();
        int cap, n, p, slot, i;
        cap = keep_cap();
        n = (kept_total < cap) ? kept_total : cap;
        p = 0;
        while (p < n && kept_max[rank_slot[p]] >= open_max) p++;
        anchor_open = 1'b0;
        if (p >= cap) return;
        slot = (n < cap) ? n : rank_slot[cap - 1];
        i = (n < cap) ? n : cap - 1;
        while (i > p)
        begin
            rank_slot[i] = rank_slot[i - 1];
            i--;
        end
        rank_slot[p] = slot;
        kept_max[slot] = open_max;
        kept_box[slot] = open_box;
        for (int c = 0; c < NC_LIMIT; c++) kept_scores[slot][c] = open_scores[c];
        kept_total = (n < cap) ? n + 1 : cap;
    endtask

    // Rank all kept scores, highest first and lowest flat index on ties, and queue the rows.
    task automatic queue_ranked_rows();
        int nc, rows, k, a, c, flat;
        logic [63:0] prev, best, key;
        bit found;
        out_item_t r;
        nc = classes_in_use();
        rows = rows_in_use();
        k = (kept_total < keep_cap()) ? kept_total : keep_cap();
        prev = '1;
        for (int t = 0; t < rows; t++)
        begin
            r = '0;
            if (t < k)
            begin
                found = 1'b0;
                best = '0;
                for (a = 0; a < k; a++)
                    for (c = 0; c < nc; c++)
                    begin
                        key = (64'(kept_scores[rank_slot[a]][c]) << 20)
                            | 64'(20'hFFFFF - 20'(a * nc + c));
                        if (key < prev && (!found || key > best))
                        begin
                            best = key;
                            found = 1'b1;
                        end
                    end
                prev = best;
                flat = int'(20'hFFFFF - best[19:0]);
                a = flat / nc;
                c = flat % nc;
                r.out_x1 = kept_box[rank_slot[a]].x1;
                r.out_y1 = kept_box[rank_slot[a]].y1;
                r.out_x2 = kept_box[rank_slot[a]].x2;
                r.out_y2 = kept_box[rank_slot[a]].y2;
                r.out_score = best[35:20];
                r.out_class = c[6:0];
            end
            r.row_last = (t + 1 == rows);
            expected_rows.push_back(r);
        end
    endtask

    // Advance the predictor by one accepted item.
    task automatic predict_item(input in_item_t it);
        int nc;
        nc = classes_in_use();
        if (it.kind == KIND_BOX)
        begin
            open_box = '{it.box_x1, it.box_y1, it.box_x2, it.box_y2};
            for (int c = 0; c < NC_LIMIT; c++) open_scores[c] = '0;
            open_max = '0;
            open_pos = 0;
            anchor_open = 1'b1;
        end
        else if (anchor_open)
        begin
            if (open_pos < nc)
            begin
                open_scores[open_pos] = it.score;
                if (it.score > open_max) open_max = it.score;
                open_pos++;
            end
            if (open_pos >= nc) insert_anchor();
        end
        if (it.last)
        begin
            queue_ranked_rows();
            for (int c = 0; c < NC_LIMIT; c++) open_scores[c] = '0;
            open_box = '0;
            open_max = '0;
            open_pos = 0;
            kept_total = 0;
            anchor_open = 1'b0;
        end
    endtask

    // Send one item, then either keep the burst going or leave a random gap.
    task automatic send_item(input in_item_t it);
        start <= 1'b1;
        item <= it;
        start_high = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_item(it);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            start_high = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    function automatic in_item_t box_item(input logic [31:0] x1, input logic [31:0] y1,
                                          input logic [31:0] x2, input logic [31:0] y2,
                                          input logic lst);
        in_item_t it;
        it = '0;
        it.kind = KIND_BOX;
        it.box_x1 = x1;
        it.box_y1 = y1;
        it.box_x2 = x2;
        it.box_y2 = y2;
        it.score = 16'($urandom);
        it.last = lst;
        return it;
    endfunction

    function automatic in_item_t score_item(input logic [15:0] s, input logic lst);
        in_item_t it;
        it = '0;
        it.kind = ~KIND_BOX;
        it.box_x1 = $urandom;
        it.box_y1 = $urandom;
        it.box_x2 = $urandom;
        it.box_y2 = $urandom;
        it.score = s;
        it.last = lst;
        return it;
    endfunction

    function automatic logic [15:0] pick_score();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic in_item_t random_box(input logic lst);
        return box_item($urandom, $urandom, $urandom, $urandom, lst);
    endfunction

    // Lower start and wait until every row has arrived and the block is idle.
    task automatic wait_drained();
        if (start_high)
        begin
            start <= 1'b0;
            start_high = 1'b0;
        end
        do
            @(posedge clk);
        while (expected_rows.size() != 0 || busy);
        repeat (20) @(posedge clk);
    endtask

    // Write all three registers back to back on the configuration channel.
    task automatic configure(input logic [7:0] nc, input logic [7:0] md, input logic [7:0] rows);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        idx = '{CFG_CLASS_COUNT, CFG_MAX_DET, CFG_OUT_ROWS};
        val = '{nc, md, rows};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (idx[i])
                CFG_CLASS_COUNT: class_count_reg = val[i];
                CFG_MAX_DET:     max_det_reg = val[i][6:0];
                CFG_OUT_ROWS:    out_rows_reg = val[i][6:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One prediction set; with irregular set, short and overlong anchors and stray scores appear.
    task automatic run_set(input int anchors, input bit irregular);
        int nc, count;
        nc = classes_in_use();
        for (int a = 0; a < anchors; a++)
        begin
            if (irregular && $urandom_range(0, 7) == 0) send_item(score_item(pick_score(), 1'b0));
            send_item(random_box(1'b0));
            count = nc;
            if (irregular && $urandom_range(0, 4) == 0) count = $urandom_range(0, nc + 2);
            for (int s = 0; s < count; s++) send_item(score_item(pick_score(), 1'b0));
        end
        if ($urandom_range(0, 1))
            send_item(score_item(pick_score(), 1'b1));
        else
            send_item(random_box(1'b1));
        wait_drained();
    endtask

    // A set with no anchors gives only zero rows at the reset settings.
    task automatic test_empty_set();
        send_item(score_item(16'hFFFF, 1'b1));
        wait_drained();
    endtask

    // Ties in maxima and scores, eviction, ignored scores and interrupted anchors.
    task automatic test_ranking();
        configure(8'd2, 8'd3, 8'd5);
        send_item(box_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_item(score_item(16'hFFFF, 1'b0));
        send_item(score_item(16'h0000, 1'b0));
        // Surplus score after the anchor has completed.
        send_item(score_item(16'h1234, 1'b0));
        send_item(box_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_item(score_item(16'd5, 1'b0));
        send_item(score_item(16'd5, 1'b0));
        send_item(box_item('0, '0, '0, '0, 1'b0));
        send_item(score_item(16'd0, 1'b0));
        send_item(score_item(16'd5, 1'b0));
        // Anchor cut short by the next box.
        send_item(box_item(32'h1, 32'h2, 32'h3, 32'h4, 1'b0));
        send_item(score_item(16'd9, 1'b0));
        send_item(box_item(32'h10, 32'h20, 32'h30, 32'h40, 1'b0));
        send_item(score_item(16'd5, 1'b0));
        send_item(score_item(16'hFFFF, 1'b0));
        // Final box leaves an incomplete anchor that is dropped.
        send_item(box_item(32'h55, 32'h66, 32'h77, 32'h88, 1'b1));
        wait_drained();
    endtask

    // Register values outside their range are clamped.
    task automatic test_clamps();
        configure(8'd0, 8'd0, 8'd0);
        send_item(random_box(1'b0));
        send_item(score_item(16'd7, 1'b0));
        send_item(random_box(1'b0));
        send_item(score_item(16'd9, 1'b1));
        wait_drained();
        configure(8'd255, 8'd127, 8'd127);
        run_set(1, 1'b0);
    endtask

    // The kept list fills to its largest size and then evicts.
    task automatic test_full_list();
        configure(8'd1, 8'd64, 8'd64);
        run_set(66, 1'b0);
    endtask

    // Random settings and random sets, mostly well formed.
    task automatic test_random_sets();
        while (items_sent < 320)
        begin
            configure(8'($urandom_range(0, 8)),
                      8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
            run_set($urandom_range(1, 6), 1'b1);
        end
    endtask

    // Compare each row with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_rows.size() == 0)
            begin
                fails++;
                if (fails <= 10) $display("unexpected row: %p", result);
            end
            else
            begin
                want = expected_rows.pop_front();
                if (result.out_x1 !== want.out_x1 || result.out_y1 !== want.out_y1 ||
                    result.out_x2 !== want.out_x2 || result.out_y2 !== want.out_y2 ||
                    result.out_score !== want.out_score ||
                    result.out_class !== want.out_class || result.row_last !== want.row_last)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("row mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fails = 0;
        items_sent = 0;
        burst_left = 0;
        start_high = 1'b0;
        class_count_reg = CLASS_COUNT_RST;
        max_det_reg = MAX_DET_RST;
        out_rows_reg = OUT_ROWS_RST;
        open_box = '0;
        open_max = '0;
        open_pos = 0;
        anchor_open = 1'b0;
        kept_total = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_set();
        test_ranking();
        test_clamps();
        test_full_list();
        test_random_sets();
        wait_drained();

        if (fails == 0 && expected_rows.size() == 0)
            $display("** detection_topk_select: PASSED **");
        else
            $display("** detection_topk_select: FAILED **");
        $finish;
    end

endmodule
